// File: design/cdda_pkg.sv
package cdda_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_YEAR   = 9999;
    localparam int DEF_COUNT_BITS = 16;

    // Command codes
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_SUB  = 2'd1;
    localparam logic [1:0] CMD_DIFF = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CLAMPED = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // x / 100 == (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2**16
    localparam int RECIP_100   = 167773;
    localparam int RECIP_SHIFT = 24;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE_MUL,
        S_BASE_LEAP,
        S_BASE_DBY_MUL,
        S_BASE_DBY,
        S_OTHER_MUL,
        S_OTHER_LEAP,
        S_OTHER_DBY_MUL,
        S_OTHER_DBY,
        S_CLAMP,
        S_SRCH_MUL,
        S_SRCH,
        S_FIN_MUL,
        S_FIN,
        S_WB
    } state_t;

    // Length of month m; 0 for a month code that means nothing
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the year before the first of month m
    function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (m > 4'd2))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// File: design/calendar_date_day_arithmetic_unit.sv
// Gregorian date arithmetic unit.
// Input channel (in_valid/in_ready) takes one item: a command, a base date,
// a day count and a second date. Output channel (out_valid/out_ready) gives
// one result item per input item: a date, a signed day difference and a
// status (ok, clamped to the year range, invalid input date).
// Add/subtract: the date is turned into a day number, the count applied with
// clamping, and the day number turned back into a date by a bit-by-bit
// search over the year, PW = clog2(MAX_YEAR+1) steps, each a multiply state
// and a search state on the shared year-to-day-number unit (one multiply
// stage plus one add). Difference: two date-to-day-number conversions.
// An invalid base or second date goes from its check straight to write-back.
// in_ready is high only while the sequencer is idle; one item is in work at
// a time, so a new item is taken only after the previous one has reached
// write-back. The result sits in an output register, so a new item is taken
// while the previous result still waits; if the receiver stalls, the next
// finished result holds in the sequencer until the output register frees.
// Reset (rst_n low) empties the unit; it leaves reset idle and ready.
module calendar_date_day_arithmetic_unit
    import cdda_pkg::*;
#(
    parameter int MAX_YEAR   = DEF_MAX_YEAR,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [4:0]         day,
    input  logic [3:0]         month,
    input  logic [13:0]        year,
    input  logic [15:0]        day_count,
    input  logic [4:0]         other_day,
    input  logic [3:0]         other_month,
    input  logic [13:0]        other_year,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [4:0]         result_day,
    output logic [3:0]         result_month,
    output logic [13:0]        result_year,
    output logic signed [22:0] difference,
    output logic [1:0]         status
);

    localparam int PW    = $clog2(MAX_YEAR + 1);
    localparam int NW    = PW + 9;
    localparam int BW    = $clog2(PW);
    localparam int CW    = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam int SW    = ((NW > CW) ? NW : CW) + 1;
    localparam int DW    = ((NW + 1) > 23) ? (NW + 1) : 23;
    localparam int MULW  = PW + 18;
    localparam int QW    = PW + 7;
    localparam int MAXN_I = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                            + MAX_YEAR / 400 - 1;
    localparam logic [NW-1:0] MAXN       = NW'(MAXN_I);
    localparam logic [16:0]   MAX_YEAR_V = 17'(MAX_YEAR);

    state_t state_reg, state_next;

    logic [1:0]    cmd_reg, cmd_next;
    logic [4:0]    d_reg, d_next, od_reg, od_next;
    logic [3:0]    m_reg, m_next, om_reg, om_next;
    logic [13:0]   y_reg, y_next, oy_reg, oy_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [PW-1:0] op_reg, op_next;
    logic [PW-1:0] q_reg;
    logic [NW-1:0] p365_reg;
    logic [NW-1:0] acc_reg, acc_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] base_reg, base_next;
    logic [PW-1:0] p_reg, p_next;
    logic [BW-1:0] bit_reg, bit_next;

    logic [4:0]  rd_reg, rd_next;
    logic [3:0]  rm_reg, rm_next;
    logic [13:0] ry_reg, ry_next;
    logic [22:0] rdiff_reg, rdiff_next;
    logic [1:0]  rst_reg, rst_next;

    logic        out_valid_reg, out_valid_next;
    logic [4:0]  out_day_reg, out_day_next;
    logic [3:0]  out_month_reg, out_month_next;
    logic [13:0] out_year_reg, out_year_next;
    logic [22:0] out_diff_reg, out_diff_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic [MULW-1:0] prod;
    logic [NW-1:0]   dby;
    logic [QW-1:0]   q100;
    logic            leap;
    logic            base_ok, other_ok;
    logic [NW-1:0]   part_base, part_other;
    logic [NW-1:0]   b_num;
    logic [DW-1:0]   diff_full;
    logic [SW-1:0]   sum_w, cnt_w, n_w;
    logic [PW-1:0]   sel_p;
    logic [NW-1:0]   rem;
    logic [8:0]      rem9;
    logic [3:0]      mon;
    logic [8:0]      day_w;
    logic            out_load;

    // Shared unit, stage 1: multiplies of the operand
    assign prod = MULW'(op_reg) * MULW'(RECIP_100);

    always_ff @(posedge clk)
    begin
        q_reg    <= PW'(prod >> RECIP_SHIFT);
        p365_reg <= NW'(op_reg) * NW'(365) + NW'(op_reg >> 2);
    end

    // Shared unit, stage 2: days before year op+1, and leap test of year op
    assign dby  = p365_reg - NW'(q_reg) + NW'(q_reg >> 2);
    assign q100 = QW'(q_reg) * QW'(100);
    assign leap = (op_reg[1:0] == 2'b00)
                  && ((q100 != QW'(op_reg)) || (q_reg[1:0] == 2'b00));

    // Date checks and day-of-year parts
    assign base_ok = (y_reg != 14'd0) && (17'(y_reg) <= MAX_YEAR_V)
                     && (m_reg >= 4'd1) && (m_reg <= 4'd12)
                     && (d_reg >= 5'd1) && (d_reg <= month_days(m_reg, leap));
    assign other_ok = (oy_reg != 14'd0) && (17'(oy_reg) <= MAX_YEAR_V)
                      && (om_reg >= 4'd1) && (om_reg <= 4'd12)
                      && (od_reg >= 5'd1) && (od_reg <= month_days(om_reg, leap));
    assign part_base  = NW'(days_before_month(m_reg, leap)) + NW'(d_reg) - NW'(1);
    assign part_other = NW'(days_before_month(om_reg, leap)) + NW'(od_reg) - NW'(1);

    assign b_num     = acc_reg + dby;
    assign diff_full = DW'(n_reg) - DW'(b_num);

    // Count with clamping
    assign n_w   = SW'(n_reg);
    assign cnt_w = SW'(cnt_reg);
    assign sum_w = n_w + cnt_w;

    // Year search choice
    assign sel_p = (dby <= n_reg) ? op_reg : p_reg;

    // Month and day from the day of the year
    assign rem  = n_reg - base_reg;
    assign rem9 = rem[8:0];

    always_comb
    begin
        mon = 4'd1;
        for (int k = 2; k <= 12; k++)
        begin
            if (days_before_month(4'(k), leap) <= rem9)
            begin
                mon = 4'(k);
            end
        end
    end

    assign day_w = rem9 - days_before_month(mon, leap) + 9'd1;

    assign out_load = (state_reg == S_WB) && (!out_valid_reg || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:          if (in_valid) state_next = S_BASE_MUL;
            S_BASE_MUL:      state_next = S_BASE_LEAP;
            S_BASE_LEAP:     state_next = base_ok ? S_BASE_DBY_MUL : S_WB;
            S_BASE_DBY_MUL:  state_next = S_BASE_DBY;
            S_BASE_DBY:      state_next = cmd_reg[1] ? S_OTHER_MUL : S_CLAMP;
            S_OTHER_MUL:     state_next = S_OTHER_LEAP;
            S_OTHER_LEAP:    state_next = other_ok ? S_OTHER_DBY_MUL : S_WB;
            S_OTHER_DBY_MUL: state_next = S_OTHER_DBY;
            S_OTHER_DBY:     state_next = S_WB;
            S_CLAMP:         state_next = S_SRCH_MUL;
            S_SRCH_MUL:      state_next = S_SRCH;
            S_SRCH:          state_next = (bit_reg == '0) ? S_FIN_MUL : S_SRCH_MUL;
            S_FIN_MUL:       state_next = S_FIN;
            S_FIN:           state_next = S_WB;
            S_WB:            if (out_load) state_next = S_IDLE;
            default:         state_next = S_IDLE;
        endcase
    end

    // Datapath and output register next values
    always_comb
    begin
        cmd_next   = cmd_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        od_next    = od_reg;
        om_next    = om_reg;
        oy_next    = oy_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        n_next     = n_reg;
        base_next  = base_reg;
        p_next     = p_reg;
        bit_next   = bit_reg;
        rd_next    = rd_reg;
        rm_next    = rm_reg;
        ry_next    = ry_reg;
        rdiff_next = rdiff_reg;
        rst_next   = rst_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_day_next    = out_day_reg;
        out_month_next  = out_month_reg;
        out_year_next   = out_year_reg;
        out_diff_next   = out_diff_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = command;
                    d_next   = day;
                    m_next   = month;
                    y_next   = year;
                    cnt_next = day_count[CW-1:0];
                    od_next  = other_day;
                    om_next  = other_month;
                    oy_next  = other_year;
                    op_next  = PW'(year);
                end
            end
            S_BASE_LEAP:
            begin
                if (!base_ok)
                begin
                    rd_next    = '0;
                    rm_next    = '0;
                    ry_next    = '0;
                    rdiff_next = '0;
                    rst_next   = ST_INVALID;
                end
                else
                begin
                    acc_next = part_base;
                    op_next  = PW'(y_reg - 14'd1);
                end
            end
            S_BASE_DBY:
            begin
                n_next  = acc_reg + dby;
                op_next = PW'(oy_reg);
            end
            S_OTHER_LEAP:
            begin
                if (!other_ok)
                begin
                    rd_next    = '0;
                    rm_next    = '0;
                    ry_next    = '0;
                    rdiff_next = '0;
                    rst_next   = ST_INVALID;
                end
                else
                begin
                    acc_next = part_other;
                    op_next  = PW'(oy_reg - 14'd1);
                end
            end
            S_OTHER_DBY:
            begin
                rd_next    = d_reg;
                rm_next    = m_reg;
                ry_next    = y_reg;
                rdiff_next = diff_full[22:0];
                rst_next   = ST_OK;
            end
            S_CLAMP:
            begin
                rdiff_next = '0;
                rst_next   = ST_OK;
                if (cmd_reg == CMD_ADD)
                begin
                    if (sum_w > SW'(MAXN))
                    begin
                        n_next   = MAXN;
                        rst_next = ST_CLAMPED;
                    end
                    else
                    begin
                        n_next = NW'(sum_w);
                    end
                end
                else
                begin
                    if (cnt_w > n_w)
                    begin
                        n_next   = '0;
                        rst_next = ST_CLAMPED;
                    end
                    else
                    begin
                        n_next = NW'(n_w - cnt_w);
                    end
                end
                p_next    = '0;
                base_next = '0;
                bit_next  = BW'(PW - 1);
                op_next   = PW'(1) << (PW - 1);
            end
            S_SRCH:
            begin
                if (dby <= n_reg)
                begin
                    p_next    = op_reg;
                    base_next = dby;
                end
                if (bit_reg != '0)
                begin
                    bit_next = bit_reg - BW'(1);
                    op_next  = sel_p | (PW'(1) << (bit_reg - BW'(1)));
                end
                else
                begin
                    op_next = sel_p + PW'(1);
                end
            end
            S_FIN:
            begin
                rd_next = day_w[4:0];
                rm_next = mon;
                ry_next = 14'(op_reg);
            end
            S_WB:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_day_next    = rd_reg;
                    out_month_next  = rm_reg;
                    out_year_next   = ry_reg;
                    out_diff_next   = rdiff_reg;
                    out_status_next = rst_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        d_reg          <= d_next;
        m_reg          <= m_next;
        y_reg          <= y_next;
        cnt_reg        <= cnt_next;
        od_reg         <= od_next;
        om_reg         <= om_next;
        oy_reg         <= oy_next;
        op_reg         <= op_next;
        acc_reg        <= acc_next;
        n_reg          <= n_next;
        base_reg       <= base_next;
        p_reg          <= p_next;
        bit_reg        <= bit_next;
        rd_reg         <= rd_next;
        rm_reg         <= rm_next;
        ry_reg         <= ry_next;
        rdiff_reg      <= rdiff_next;
        rst_reg        <= rst_next;
        out_day_reg    <= out_day_next;
        out_month_reg  <= out_month_next;
        out_year_reg   <= out_year_next;
        out_diff_reg   <= out_diff_next;
        out_status_reg <= out_status_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_day   = out_day_reg;
    assign result_month = out_month_reg;
    assign result_year  = out_year_reg;
    assign difference   = $signed(out_diff_reg);
    assign status       = out_status_reg;

    // Busy for the whole item once it is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("unit ready right after taking an item");

    // Invalid input gives all-zero result fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_INVALID)) |->
        ((result_day == 5'd0) && (result_month == 4'd0)
         && (result_year == 14'd0) && (difference == 23'sd0)))
        else $error("invalid item with nonzero result");

    // A good result has a month in 1..12 and a nonzero day
    a_date_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_INVALID)) |->
        ((result_month >= 4'd1) && (result_month <= 4'd12) && (result_day >= 5'd1)))
        else $error("result date out of shape");

    // Year search never settles beyond the last year
    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (17'(p_reg) < MAX_YEAR_V))
        else $error("year search past the last year");

endmodule
